// File: hw/rtl/swipe_gesture_detector_assert.svh
// Assertion macros used by the swipe detector RTL.
`ifndef SWIPE_GESTURE_DETECTOR_ASSERT_SVH
`define SWIPE_GESTURE_DETECTOR_ASSERT_SVH

// Checks a consequence in the same cycle as its cause.
`define SWD_ASSERT_SAME(label, clk, rst_n, cause, effect) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cause) |-> (effect)) \
        else $error("swipe detector check failed");

// Checks a consequence in the cycle after its cause.
`define SWD_ASSERT_NEXT(label, clk, rst_n, cause, effect) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cause) |=> (effect)) \
        else $error("swipe detector check failed");

`endif

// File: hw/rtl/swd_pkg.sv
package swd_pkg;

    localparam int KIND_W       = 2;
    localparam int CODE_W       = 16;
    localparam int DELTA_W      = 16;
    localparam int ACC_W        = 32;
    localparam int CFG_W        = 64;
    localparam int CFG_IDX_W    = 3;
    localparam int CNT_W        = 3;
    localparam int PACKED_CODES = 4;
    localparam int AXIS_W       = 2;
    localparam int BIND_W       = AXIS_W + 1;
    localparam int PARAM_W      = 16;

    localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_MOTION  = 2'd1;

    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IDLE_TO    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_THROTTLE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PASS       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS_CODES = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS_COUNT = 3'd5;

    localparam logic [PARAM_W-1:0] THRESHOLD_RST = 16'd100;
    localparam logic [PARAM_W-1:0] IDLE_TO_RST   = 16'd300;
    localparam logic [PARAM_W-1:0] THROTTLE_RST  = 16'd0;

    typedef struct packed {
        logic              hit;
        logic [AXIS_W-1:0] axis;
    } t_match;

endpackage

// File: hw/rtl/swd_match.sv
module swd_match import swd_pkg::*; #(
    parameter int NUM_LANES = 4
) (
    input  logic [CODE_W-1:0]              i_code,
    input  logic [PACKED_CODES*CODE_W-1:0] i_axis_codes,
    input  logic [CNT_W-1:0]               i_axis_count,
    output t_match                         o_match
);

    logic [CNT_W-1:0] w_limit;

    // Scanning from the top down leaves the lowest matching axis in place.
    always_comb begin
        w_limit = (i_axis_count > CNT_W'(NUM_LANES)) ? CNT_W'(NUM_LANES) : i_axis_count;
        o_match = '0;
        for (int i = NUM_LANES - 1; i >= 0; i--) begin
            if ((CNT_W'(i) < w_limit) && (i_axis_codes[i*CODE_W +: CODE_W] == i_code)) begin
                o_match.hit  = 1'b1;
                o_match.axis = AXIS_W'(i);
            end
        end
    end

endmodule

// File: hw/rtl/swipe_gesture_detector.sv
// Channel   Dir  Width         Contents
// s_axis    in   tuser 2       event kind
//                tdata 80      event code, motion delta, timestamp
// m_axis    out  tdata 24      fired, fire binding, forward flag, output delta
// cfg       in   idx 3, 64     one register write per cycle with i_cfg_we
//
// Each event goes through an input register and the combinational compute logic into the
// result register, so the block takes one event per cycle while the output is not stalled.
// The per-axis accumulate, peak and fire logic sits in that compute logic.
// Synchronous active-low reset clears the axis state, the lock, the timestamps
// and loads the register defaults.
// A stalled output holds its result while one more event waits in the input register.
`include "swipe_gesture_detector_assert.svh"

module swipe_gesture_detector import swd_pkg::*; #(
    parameter int NUM_AXES   = 4,
    parameter int TIME_WIDTH = 48
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // event_kind
    input  logic [KIND_W-1:0]    s_axis_tuser,
    // event_code, motion_delta, timestamp_ms, zero fill
    input  logic [((CODE_W + DELTA_W + TIME_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // fired, fire_binding, forward_event, out_delta, zero fill
    output logic [23:0]          m_axis_tdata
);

    localparam int LANES    = (NUM_AXES < PACKED_CODES) ? NUM_AXES : PACKED_CODES;
    localparam int OUT_BITS = 1 + BIND_W + 1 + DELTA_W;
    localparam int OUT_W    = 24;

    function automatic logic [ACC_W-1:0] mag32(input logic [ACC_W-1:0] v);
        return v[ACC_W-1] ? (~v + ACC_W'(1)) : v;
    endfunction

    function automatic logic [ACC_W:0] mag33(input logic [ACC_W:0] v);
        return v[ACC_W] ? (~v + (ACC_W+1)'(1)) : v;
    endfunction

    // Configuration registers
    logic [PARAM_W-1:0]             r_threshold;
    logic [PARAM_W-1:0]             r_idle_to;
    logic [PARAM_W-1:0]             r_throttle;
    logic                           r_pass;
    logic [PACKED_CODES*CODE_W-1:0] r_axis_codes;
    logic [CNT_W-1:0]               r_axis_count;

    // Input stage
    logic                  r_in_valid;
    logic [KIND_W-1:0]     r_in_kind;
    logic [CODE_W-1:0]     r_in_code;
    logic [DELTA_W-1:0]    r_in_delta;
    logic [TIME_WIDTH-1:0] r_in_time;

    // Detector state
    logic [LANES-1:0][ACC_W-1:0] r_accum, n_accum;
    logic [LANES-1:0][ACC_W-1:0] r_peak, n_peak;
    logic                        r_locked, n_locked;
    logic [TIME_WIDTH-1:0]       r_last_event, n_last_event;
    logic [TIME_WIDTH-1:0]       r_last_fire, n_last_fire;

    // Result register
    logic               r_out_valid;
    logic               r_out_fired, n_out_fired;
    logic [BIND_W-1:0]  r_out_bind, n_out_bind;
    logic               r_out_fwd, n_out_fwd;
    logic [DELTA_W-1:0] r_out_delta, n_out_delta;

    logic                  w_adv;
    logic                  w_go;
    logic                  w_take;
    t_match                w_match;
    logic                  w_motion;
    logic [TIME_WIDTH-1:0] w_idle_gap;
    logic [TIME_WIDTH-1:0] w_fire_gap;
    logic                  w_idle_clr;
    logic                  w_thr_clr;
    logic                  w_clr;
    logic                  w_locked_eff;
    logic [ACC_W-1:0]      w_acc_sel;
    logic [ACC_W-1:0]      w_peak_sel;
    logic [ACC_W-1:0]      w_delta_ext;
    logic [ACC_W:0]        w_sum;
    logic [ACC_W-1:0]      w_acc_sat;
    logic [ACC_W:0]        w_pull;
    logic [ACC_W-1:0]      w_acc_new;
    logic [ACC_W-1:0]      w_peak_new;
    logic                  w_fire;
    logic                  w_peak_ok;

    assign w_adv         = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || w_adv;
    assign w_take        = s_axis_tvalid && s_axis_tready;
    assign w_go          = r_in_valid && w_adv;

    swd_match #(
        .NUM_LANES (LANES)
    ) u_match (
        .i_code       (r_in_code),
        .i_axis_codes (r_axis_codes),
        .i_axis_count (r_axis_count),
        .o_match      (w_match)
    );

    assign w_motion = (r_in_kind == KIND_MOTION) && w_match.hit;

    // The idle check runs first; the throttle check sees the lock it leaves.
    assign w_idle_gap   = r_in_time - r_last_event;
    assign w_fire_gap   = r_in_time - r_last_fire;
    assign w_idle_clr   = (r_last_event != '0) && (w_idle_gap > TIME_WIDTH'(r_idle_to));
    assign w_thr_clr    = r_locked && !w_idle_clr && (r_throttle != '0) &&
                          (w_fire_gap >= TIME_WIDTH'(r_throttle));
    assign w_clr        = w_idle_clr || w_thr_clr;
    assign w_locked_eff = r_locked && !w_clr;

    always_comb begin
        w_acc_sel  = '0;
        w_peak_sel = '0;
        for (int i = 0; i < LANES; i++) begin
            if (!w_clr && (w_match.axis == AXIS_W'(i))) begin
                w_acc_sel  = r_accum[i];
                w_peak_sel = r_peak[i];
            end
        end
    end

    assign w_delta_ext = {{(ACC_W-DELTA_W){r_in_delta[DELTA_W-1]}}, r_in_delta};
    assign w_sum       = {w_acc_sel[ACC_W-1], w_acc_sel} + {w_delta_ext[ACC_W-1], w_delta_ext};

    always_comb begin
        if (w_sum[ACC_W] != w_sum[ACC_W-1]) begin
            w_acc_sat = w_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
            w_acc_sat = w_sum[ACC_W-1:0];
        end
    end

    assign w_pull = {w_peak_sel[ACC_W-1], w_peak_sel} - {w_acc_sat[ACC_W-1], w_acc_sat};

    // A pull-back of half the threshold from the peak restarts the run at the delta.
    always_comb begin
        if (r_in_delta == '0) begin
            w_acc_new  = w_acc_sel;
            w_peak_new = w_peak_sel;
        end else if (mag32(w_acc_sat) > mag32(w_peak_sel)) begin
            w_acc_new  = w_acc_sat;
            w_peak_new = w_acc_sat;
        end else if (mag33(w_pull) >= (ACC_W+1)'(r_threshold[PARAM_W-1:1])) begin
            w_acc_new  = w_delta_ext;
            w_peak_new = w_delta_ext;
        end else begin
            w_acc_new  = w_acc_sat;
            w_peak_new = w_peak_sel;
        end
    end

    assign w_fire = w_motion && !w_locked_eff && (mag32(w_acc_new) >= ACC_W'(r_threshold));

    always_comb begin
        n_accum      = r_accum;
        n_peak       = r_peak;
        n_locked     = r_locked;
        n_last_event = r_last_event;
        n_last_fire  = r_last_fire;
        n_out_fired  = 1'b0;
        n_out_bind   = '0;
        n_out_fwd    = 1'b1;
        n_out_delta  = r_in_delta;
        if (r_in_kind == KIND_RELEASE) begin
            n_accum  = '0;
            n_peak   = '0;
            n_locked = 1'b0;
        end else if (w_motion) begin
            n_last_event = r_in_time;
            n_out_fwd    = r_pass;
            if (!r_pass) begin
                n_out_delta = '0;
            end
            if (w_fire) begin
                n_accum     = '0;
                n_peak      = '0;
                n_locked    = 1'b1;
                n_last_fire = r_in_time;
                n_out_fired = 1'b1;
                n_out_bind  = {w_match.axis, !w_acc_new[ACC_W-1] && (w_acc_new != '0)};
            end else begin
                n_locked = w_locked_eff;
                for (int i = 0; i < LANES; i++) begin
                    if (w_match.axis == AXIS_W'(i)) begin
                        n_accum[i] = w_acc_new;
                        n_peak[i]  = w_peak_new;
                    end else if (w_clr) begin
                        n_accum[i] = '0;
                        n_peak[i]  = '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold  <= THRESHOLD_RST;
            r_idle_to    <= IDLE_TO_RST;
            r_throttle   <= THROTTLE_RST;
            r_pass       <= 1'b0;
            r_axis_codes <= '0;
            r_axis_count <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_THRESHOLD:  r_threshold  <= i_cfg_data[PARAM_W-1:0];
                REG_IDLE_TO:    r_idle_to    <= i_cfg_data[PARAM_W-1:0];
                REG_THROTTLE:   r_throttle   <= i_cfg_data[PARAM_W-1:0];
                REG_PASS:       r_pass       <= i_cfg_data[0];
                REG_AXIS_CODES: r_axis_codes <= i_cfg_data[PACKED_CODES*CODE_W-1:0];
                REG_AXIS_COUNT: r_axis_count <= i_cfg_data[CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_accum      <= '0;
            r_peak       <= '0;
            r_locked     <= 1'b0;
            r_last_event <= '0;
            r_last_fire  <= '0;
        end else begin
            if (w_take) begin
                r_in_valid <= 1'b1;
            end else if (w_go) begin
                r_in_valid <= 1'b0;
            end
            if (w_go) begin
                r_out_valid  <= 1'b1;
                r_accum      <= n_accum;
                r_peak       <= n_peak;
                r_locked     <= n_locked;
                r_last_event <= n_last_event;
                r_last_fire  <= n_last_fire;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in_kind  <= s_axis_tuser;
            r_in_code  <= s_axis_tdata[CODE_W-1:0];
            r_in_delta <= s_axis_tdata[CODE_W +: DELTA_W];
            r_in_time  <= s_axis_tdata[CODE_W + DELTA_W +: TIME_WIDTH];
        end
        if (w_go) begin
            r_out_fired <= n_out_fired;
            r_out_bind  <= n_out_bind;
            r_out_fwd   <= n_out_fwd;
            r_out_delta <= n_out_delta;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_W-OUT_BITS){1'b0}}, r_out_delta, r_out_fwd, r_out_bind,
                            r_out_fired};

    // Every accumulator stays within the magnitude of its own peak.
    always_comb begin
        w_peak_ok = 1'b1;
        for (int i = 0; i < LANES; i++) begin
            if (mag32(r_accum[i]) > mag32(r_peak[i])) begin
                w_peak_ok = 1'b0;
            end
        end
    end

    `SWD_ASSERT_SAME(a_peak_bounds_accum, i_clk, i_rst_n, 1'b1, w_peak_ok)
    `SWD_ASSERT_NEXT(a_fire_locks_and_clears, i_clk, i_rst_n, w_go && w_fire,
                     r_locked && (r_accum == '0) && (r_peak == '0))
    `SWD_ASSERT_NEXT(a_input_held_on_stall, i_clk, i_rst_n, r_in_valid && !w_adv, r_in_valid)
    `SWD_ASSERT_SAME(a_fire_obeys_pass, i_clk, i_rst_n, r_out_valid && r_out_fired,
                     r_out_fwd == r_pass)
    `SWD_ASSERT_SAME(a_fire_axis_in_range, i_clk, i_rst_n, r_out_valid && r_out_fired,
                     r_out_bind[BIND_W-1:1] < AXIS_W'(LANES - 1) ||
                     r_out_bind[BIND_W-1:1] == AXIS_W'(LANES - 1))

endmodule
